// ===== rtl/core/itrd_pkg.sv =====
// itrd_pkg: shared types, constants and the symbol lookup for the radix digit converter
// no dependencies; imported by every module of the block
package itrd_pkg;

    // operand width and divider slicing
    localparam int VALUE_WIDTH = 64;
    localparam int IN_WIDTH    = 64;
    localparam int STEP_BITS   = 8;
    localparam int DIV_STEPS   = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_W       = DIV_STEPS * STEP_BITS;
    localparam int STEP_CNT_W  = $clog2(DIV_STEPS + 1);

    // digit store
    localparam int STORE_DEPTH = 64;
    localparam int STORE_AW    = 6;
    localparam int COUNT_W     = 7;
    localparam int DIGIT_W     = 4;

    // radix and symbol table
    localparam int RADIX_W     = 5;
    localparam int SYM_W       = 8;
    localparam int TAB_W       = 64;

    // configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_HI = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET  = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN    = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX    = 5'd16;
    localparam logic [TAB_W-1:0]   SYM_LO_RESET = 64'h3736_3534_3332_3130;
    localparam logic [TAB_W-1:0]   SYM_HI_RESET = 64'h0000_0000_0000_3938;

    // queue between front and back
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_AW     = 1;
    localparam int FIFO_CNT_W  = 2;

    // one classified conversion job
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [RADIX_W-1:0]     radix;
    } job_t;

    // symbol table as held in the configuration registers
    typedef struct packed {
        logic [TAB_W-1:0] lo;
        logic [TAB_W-1:0] hi;
    } symtab_t;

    // pick the symbol byte of one digit value
    function automatic logic [SYM_W-1:0] symbol_of(input symtab_t tab,
                                                  input logic [DIGIT_W-1:0] d);
        logic [SYM_W-1:0] s;
        if (d[3]) begin
            s = tab.hi[d[2:0]*SYM_W +: SYM_W];
        end else begin
            s = tab.lo[d[2:0]*SYM_W +: SYM_W];
        end
        return s;
    endfunction

endpackage

// ===== rtl/core/itrd_front.sv =====
// itrd_front: input register stage; masks the value and clamps the radix
// depends on itrd_pkg
module itrd_front import itrd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [IN_WIDTH-1:0] s_value,
    input  logic [RADIX_W-1:0]  radix_cfg,
    output logic                push_valid,
    input  logic                push_ready,
    output job_t                push_job
);

    logic               valid_reg;
    job_t               job_reg;
    job_t               job_next;
    logic [RADIX_W-1:0] radix_eff;

    // clamp radix into 2..16
    always_comb begin
        if (radix_cfg < RADIX_MIN) begin
            radix_eff = RADIX_MIN;
        end else if (radix_cfg > RADIX_MAX) begin
            radix_eff = RADIX_MAX;
        end else begin
            radix_eff = radix_cfg;
        end
        job_next.value = s_value[VALUE_WIDTH-1:0];
        job_next.radix = radix_eff;
    end

    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_job   = job_reg;

    // holding register toward the queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            job_reg <= job_next;
        end
    end

endmodule

// ===== rtl/core/itrd_fifo.sv =====
// itrd_fifo: two-entry job queue between front and back
// depends on itrd_pkg
module itrd_fifo import itrd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    wr_ptr_reg;
    logic [FIFO_AW-1:0]    rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/core/itrd_back.sv =====
// itrd_back: digit extraction by repeated division, digit store, symbol output
// depends on itrd_pkg
module itrd_back import itrd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             job_valid,
    output logic             job_ready,
    input  job_t             job,
    input  symtab_t          tab,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [SYM_W-1:0] m_symbol,
    output logic             m_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FETCH,
        ST_LOAD,
        ST_SHOW
    } state_t;

    state_t                 state_reg;
    logic [DIV_W-1:0]       quot_reg;
    logic [RADIX_W-1:0]     radix_reg;
    logic [DIGIT_W-1:0]     rem_reg;
    logic [STEP_CNT_W-1:0]  step_reg;
    logic [COUNT_W-1:0]     n_reg;
    logic [STORE_AW-1:0]    ptr_reg;
    logic                   m_valid_reg;
    logic [SYM_W-1:0]       sym_reg;
    logic                   last_reg;

    logic [DIGIT_W-1:0]     store_mem [STORE_DEPTH];
    logic [DIGIT_W-1:0]     rd_data_reg;

    logic [DIGIT_W-1:0]     rem_next;
    logic [STEP_BITS-1:0]   qbyte;
    logic [DIV_W-1:0]       quot_next;
    logic [COUNT_W-1:0]     n_next;
    logic                   step_last;
    logic                   digit_done;

    // one slice of restoring division: STEP_BITS quotient bits per cycle
    always_comb begin
        logic [RADIX_W-1:0] trial;
        logic [RADIX_W-1:0] diff;
        rem_next = rem_reg;
        qbyte    = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {rem_next, quot_reg[DIV_W-1-i]};
            diff  = trial - radix_reg;
            if (trial >= radix_reg) begin
                qbyte[STEP_BITS-1-i] = 1'b1;
                rem_next             = diff[DIGIT_W-1:0];
            end else begin
                rem_next = trial[DIGIT_W-1:0];
            end
        end
        quot_next = (quot_reg << STEP_BITS) | DIV_W'(qbyte);
    end

    assign step_last  = (step_reg == STEP_CNT_W'(DIV_STEPS - 1));
    assign n_next     = n_reg + 1'b1;
    assign digit_done = (state_reg == ST_DIVIDE) && step_last;

    assign job_ready = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_symbol  = sym_reg;
    assign m_last    = last_reg;

    // sequencer: divide, then read digits back most significant first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            n_reg       <= '0;
            step_reg    <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        quot_reg  <= DIV_W'(job.value);
                        radix_reg <= job.radix;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        n_reg     <= '0;
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: begin
                    quot_reg <= quot_next;
                    if (step_last) begin
                        rem_reg  <= '0;
                        step_reg <= '0;
                        n_reg    <= n_next;
                        if (quot_next == '0 || n_next == COUNT_W'(STORE_DEPTH)) begin
                            ptr_reg   <= n_reg[STORE_AW-1:0];
                            state_reg <= ST_FETCH;
                        end
                    end else begin
                        rem_reg  <= rem_next;
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    sym_reg     <= symbol_of(tab, rd_data_reg);
                    last_reg    <= (ptr_reg == '0);
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_SHOW;
                end
                ST_SHOW: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            ptr_reg   <= ptr_reg - 1'b1;
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // digit store: written once per finished digit, registered read
    always_ff @(posedge aclk) begin
        if (digit_done) begin
            store_mem[n_reg[STORE_AW-1:0]] <= rem_next;
        end
        rd_data_reg <= store_mem[ptr_reg];
    end

endmodule

// ===== rtl/core/integer_to_radix_digits.sv =====
// integer_to_radix_digits: top level; configuration registers, front stage, job queue, back end
// depends on itrd_pkg, itrd_front, itrd_fifo, itrd_back
//
//   port group   direction   handshake            payload
//   s_*          in          s_valid / s_ready    s_value (64 bit unsigned)
//   m_*          out         m_valid / m_ready    m_symbol (8 bit), m_last
//   cfg_*        in          cfg_wr_en            cfg_index, cfg_wdata
//
// each digit is the remainder of a division by the radix in the 8-bit-per-cycle divider; when
// all digits are found, they are read back from the digit store, most significant first, and
// presented one per output transfer (radix 10: up to 20 digits, radix 2: up to 64)
// reset is synchronous, active low, and clears all control state; no clearing pass is needed
// a two-entry queue lets the input side keep accepting items while the back end is busy
// or waiting on m_ready
module integer_to_radix_digits import itrd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [IN_WIDTH-1:0]   s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SYM_W-1:0]      m_symbol,
    output logic                  m_last,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [RADIX_W-1:0] radix_reg;
    symtab_t            tab_reg;

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg  <= RADIX_RESET;
            tab_reg.lo <= SYM_LO_RESET;
            tab_reg.hi <= SYM_HI_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_RADIX:  radix_reg  <= cfg_wdata[RADIX_W-1:0];
                CFG_SYM_LO: tab_reg.lo <= cfg_wdata;
                CFG_SYM_HI: tab_reg.hi <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // accept and classify
    itrd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .radix_cfg  (radix_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // job queue
    itrd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // conversion and output
    itrd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .tab       (tab_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_symbol  (m_symbol),
        .m_last    (m_last)
    );

endmodule
